>>> rtl/erid_pkg.sv
// Shared types and constants for the escape run-length image decoder.
// Depends on nothing; every other file in rtl/ refers to it by scoped names.
`default_nettype none

package erid_pkg;

    localparam logic [7:0] ESCAPE_BYTE = 8'hFF;

    // Depth of the command queue between front and back. Must be a power of two.
    localparam int CMD_FIFO_DEPTH = 2;
    localparam int CMD_PTR_W      = (CMD_FIFO_DEPTH > 1) ? $clog2(CMD_FIFO_DEPTH) : 1;
    localparam int CMD_CNT_W      = $clog2(CMD_FIFO_DEPTH + 1);

    typedef enum logic [1:0] {
        KIND_HEADER = 2'd0,
        KIND_BAD    = 2'd1,
        KIND_RUN    = 2'd2
    } kind_t;

    typedef enum logic [3:0] {
        PH_HDR0   = 4'd0,
        PH_HDR1   = 4'd1,
        PH_HDR2   = 4'd2,
        PH_HDR3   = 4'd3,
        PH_HDR4   = 4'd4,
        PH_HDR5   = 4'd5,
        PH_HDR6   = 4'd6,
        PH_HDR7   = 4'd7,
        PH_IGNORE = 4'd8,
        PH_IDLE   = 4'd9,
        PH_VALUE  = 4'd10,
        PH_CLOW   = 4'd11,
        PH_CHIGH  = 4'd12
    } phase_t;

    // One classified command from the parser to the executor.
    typedef struct packed {
        kind_t       kind;
        logic [15:0] width;
        logic [15:0] height;
        logic [7:0]  value;
        logic [15:0] length;
    } cmd_t;

    // Magic tag "NOVA", one byte per header position.
    function automatic logic [7:0] magic_byte(input logic [1:0] idx);
        logic [7:0] b;
        unique case (idx)
            2'd0: b = 8'h4E;
            2'd1: b = 8'h4F;
            2'd2: b = 8'h56;
            2'd3: b = 8'h41;
            default: b = 8'h00;
        endcase
        return b;
    endfunction

endpackage

`default_nettype wire

>>> rtl/erid_front.sv
// Byte parser: header check, escape assembly, literal classification.
// Depends on erid_pkg for the phase encoding and the command struct.
`default_nettype none

module erid_front (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  in_accept,
    input  wire  [7:0]           in_byte,
    input  wire                  in_sof,
    output logic                 cmd_push,
    output erid_pkg::cmd_t       cmd
);

    erid_pkg::phase_t phase_reg, phase_next;
    logic             match_reg, match_next;
    logic [15:0]      width_reg, width_next;
    logic [15:0]      height_reg, height_next;
    logic [7:0]       esc_value_reg, esc_value_next;
    logic [7:0]       count_low_reg, count_low_next;

    erid_pkg::phase_t ph;
    logic             mm;
    logic             cmd_valid;
    logic [15:0]      esc_len;

    always_comb begin
        // A start-of-file byte is always header byte zero with a fresh match flag.
        ph             = in_sof ? erid_pkg::PH_HDR0 : phase_reg;
        mm             = in_sof ? 1'b1 : match_reg;
        esc_len        = {in_byte, count_low_reg};
        phase_next     = ph;
        match_next     = mm;
        width_next     = width_reg;
        height_next    = height_reg;
        esc_value_next = esc_value_reg;
        count_low_next = count_low_reg;
        cmd_valid      = 1'b0;
        cmd            = '0;
        unique case (ph)
            erid_pkg::PH_HDR0: begin
                match_next = mm && (in_byte == erid_pkg::magic_byte(2'd0));
                phase_next = erid_pkg::PH_HDR1;
            end
            erid_pkg::PH_HDR1: begin
                match_next = mm && (in_byte == erid_pkg::magic_byte(2'd1));
                phase_next = erid_pkg::PH_HDR2;
            end
            erid_pkg::PH_HDR2: begin
                match_next = mm && (in_byte == erid_pkg::magic_byte(2'd2));
                phase_next = erid_pkg::PH_HDR3;
            end
            erid_pkg::PH_HDR3: begin
                match_next = mm && (in_byte == erid_pkg::magic_byte(2'd3));
                phase_next = erid_pkg::PH_HDR4;
            end
            erid_pkg::PH_HDR4: begin
                width_next[7:0] = in_byte;
                phase_next      = erid_pkg::PH_HDR5;
            end
            erid_pkg::PH_HDR5: begin
                width_next[15:8] = in_byte;
                phase_next       = erid_pkg::PH_HDR6;
            end
            erid_pkg::PH_HDR6: begin
                height_next[7:0] = in_byte;
                phase_next       = erid_pkg::PH_HDR7;
            end
            erid_pkg::PH_HDR7: begin
                height_next[15:8] = in_byte;
                cmd_valid         = 1'b1;
                if (mm) begin
                    cmd.kind   = erid_pkg::KIND_HEADER;
                    cmd.width  = width_reg;
                    cmd.height = {in_byte, height_reg[7:0]};
                    phase_next = erid_pkg::PH_IDLE;
                end else begin
                    cmd.kind   = erid_pkg::KIND_BAD;
                    phase_next = erid_pkg::PH_IGNORE;
                end
            end
            erid_pkg::PH_IGNORE: begin
                phase_next = erid_pkg::PH_IGNORE;
            end
            erid_pkg::PH_VALUE: begin
                esc_value_next = in_byte;
                phase_next     = erid_pkg::PH_CLOW;
            end
            erid_pkg::PH_CLOW: begin
                count_low_next = in_byte;
                phase_next     = erid_pkg::PH_CHIGH;
            end
            erid_pkg::PH_CHIGH: begin
                phase_next = erid_pkg::PH_IDLE;
                // An escape with a zero count produces nothing.
                if (esc_len != 16'd0) begin
                    cmd_valid  = 1'b1;
                    cmd.kind   = erid_pkg::KIND_RUN;
                    cmd.value  = esc_value_reg;
                    cmd.length = esc_len;
                end
            end
            default: begin
                // Pixel idle; unused codes behave the same way.
                if (in_byte == erid_pkg::ESCAPE_BYTE) begin
                    phase_next = erid_pkg::PH_VALUE;
                end else begin
                    phase_next = erid_pkg::PH_IDLE;
                    cmd_valid  = 1'b1;
                    cmd.kind   = erid_pkg::KIND_RUN;
                    cmd.value  = in_byte;
                    cmd.length = 16'd1;
                end
            end
        endcase
        cmd_push = in_accept && cmd_valid;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg     <= erid_pkg::PH_HDR0;
            match_reg     <= 1'b1;
            width_reg     <= '0;
            height_reg    <= '0;
            esc_value_reg <= '0;
            count_low_reg <= '0;
        end else if (in_accept) begin
            phase_reg     <= phase_next;
            match_reg     <= match_next;
            width_reg     <= width_next;
            height_reg    <= height_next;
            esc_value_reg <= esc_value_next;
            count_low_reg <= count_low_next;
        end
    end

endmodule

`default_nettype wire

>>> rtl/erid_cmd_fifo.sv
// Short command queue between parser and executor, flip-flop storage.
// Depends on erid_pkg for the command struct and queue depth.
`default_nettype none

module erid_cmd_fifo (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  push,
    input  erid_pkg::cmd_t       push_cmd,
    output logic                 has_room,
    input  wire                  pop,
    output logic                 head_valid,
    output erid_pkg::cmd_t       head_cmd
);

    erid_pkg::cmd_t                   store [erid_pkg::CMD_FIFO_DEPTH];
    logic [erid_pkg::CMD_PTR_W-1:0]   wr_ptr_reg;
    logic [erid_pkg::CMD_PTR_W-1:0]   rd_ptr_reg;
    logic [erid_pkg::CMD_CNT_W-1:0]   count_reg, count_next;

    assign has_room   = count_reg < erid_pkg::CMD_CNT_W'(erid_pkg::CMD_FIFO_DEPTH);
    assign head_valid = count_reg != '0;
    assign head_cmd   = store[rd_ptr_reg];

    always_comb begin
        count_next = count_reg;
        if (push && !pop) begin
            count_next = count_reg + 1'b1;
        end else if (pop && !push) begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            if (push) begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (pop) begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            store[wr_ptr_reg] <= push_cmd;
        end
    end

    a_no_overflow: assert property (@(posedge aclk) disable iff (!aresetn)
        push |-> (has_room || pop))
        else $error("command pushed into a full queue");

endmodule

`default_nettype wire

>>> rtl/erid_back.sv
// Executor: tracks pixel position against width*height and holds the output register.
// Depends on erid_pkg for the command struct and result kinds.
`default_nettype none

module erid_back (
    input  wire                  aclk,
    input  wire                  aresetn,
    input  wire                  head_valid,
    input  erid_pkg::cmd_t       head_cmd,
    output logic                 pop,
    input  wire                  out_ready,
    output logic                 out_valid,
    output erid_pkg::kind_t      out_kind,
    output logic [15:0]          out_width,
    output logic [15:0]          out_height,
    output logic [31:0]          out_start,
    output logic [7:0]           out_value,
    output logic [15:0]          out_length,
    output logic                 out_overrun
);

    logic            valid_reg;
    erid_pkg::kind_t kind_reg;
    logic [15:0]     width_reg, height_reg, length_reg;
    logic [31:0]     start_reg;
    logic [7:0]      value_reg;
    logic            overrun_reg;

    logic [31:0]     pos_reg, pos_next;
    logic [31:0]     total_reg, total_next;
    logic [32:0]     end_sum;
    logic            over;

    assign pop     = head_valid && (!valid_reg || out_ready);
    assign end_sum = {1'b0, pos_reg} + {17'd0, head_cmd.length};
    assign over    = end_sum > {1'b0, total_reg};

    always_comb begin
        pos_next   = pos_reg;
        total_next = total_reg;
        unique case (head_cmd.kind)
            erid_pkg::KIND_HEADER: begin
                pos_next   = '0;
                total_next = {16'd0, head_cmd.width} * {16'd0, head_cmd.height};
            end
            erid_pkg::KIND_RUN: begin
                pos_next = over ? total_reg : end_sum[31:0];
            end
            default: begin
                pos_next = pos_reg;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
            pos_reg   <= '0;
            total_reg <= '0;
        end else begin
            if (pop) begin
                valid_reg <= 1'b1;
                pos_reg   <= pos_next;
                total_reg <= total_next;
            end else if (out_ready) begin
                valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (pop) begin
            kind_reg    <= head_cmd.kind;
            width_reg   <= '0;
            height_reg  <= '0;
            start_reg   <= '0;
            value_reg   <= '0;
            length_reg  <= '0;
            overrun_reg <= 1'b0;
            if (head_cmd.kind == erid_pkg::KIND_HEADER) begin
                width_reg  <= head_cmd.width;
                height_reg <= head_cmd.height;
            end else if (head_cmd.kind == erid_pkg::KIND_RUN) begin
                start_reg   <= pos_reg;
                value_reg   <= head_cmd.value;
                length_reg  <= head_cmd.length;
                overrun_reg <= over;
            end
        end
    end

    assign out_valid   = valid_reg;
    assign out_kind    = kind_reg;
    assign out_width   = width_reg;
    assign out_height  = height_reg;
    assign out_start   = start_reg;
    assign out_value   = value_reg;
    assign out_length  = length_reg;
    assign out_overrun = overrun_reg;

    a_pos_bounded: assert property (@(posedge aclk) disable iff (!aresetn)
        pos_reg <= total_reg)
        else $error("pixel position beyond image size");

    a_run_nonzero: assert property (@(posedge aclk) disable iff (!aresetn)
        (valid_reg && kind_reg == erid_pkg::KIND_RUN) |-> (length_reg != 16'd0))
        else $error("run record with zero length");

    a_header_resets_pos: assert property (@(posedge aclk) disable iff (!aresetn)
        (pop && head_cmd.kind == erid_pkg::KIND_HEADER) |=> (pos_reg == 32'd0))
        else $error("header did not rewind pixel position");

endmodule

`default_nettype wire

>>> rtl/escape_rle_image_decoder.sv
// Top level of the escape run-length image decoder: parser, command queue, executor.
// Depends on erid_pkg, erid_front, erid_cmd_fifo and erid_back.
`default_nettype none

//  Channel | Direction | tdata                                  | tuser
//  --------+-----------+----------------------------------------+-------------------
//  s_      | in        | data_byte[7:0]                         | start_of_file
//  m_      | out       | width, height, start, value, length,   | kind (0 header,
//          |           | overrun (see port comment), 96 bits    | 1 bad, 2 run)
//
// One byte beat is accepted per cycle while s_tready is high; a result reaches m_
// after the beat that causes it, by way of the parser's queue write and then the output
// register, and results flow at one per cycle while m_tready is high. The rate is set
// by the parser's phase update per beat and the executor's one add-and-compare per run.
// aresetn is synchronous and active low; it restarts the parser at header byte zero
// and empties the queue and output register. When m_tready is held low the output
// register and the two-entry queue fill, and s_tready drops only when the queue is full.

module escape_rle_image_decoder (
    input  wire          aclk,
    input  wire          aresetn,
    input  wire          s_tvalid,
    output logic         s_tready,
    input  wire  [7:0]   s_tdata,   // [7:0] data_byte
    input  wire  [0:0]   s_tuser,   // [0] start_of_file
    output logic         m_tvalid,
    input  wire          m_tready,
    // [15:0] image_width, [31:16] image_height, [63:32] run_start,
    // [71:64] pixel_value, [87:72] run_length, [88] overrun, [95:89] zero
    output logic [95:0]  m_tdata,
    output logic [1:0]   m_tuser    // [1:0] kind
);

    logic            in_accept;
    logic            cmd_push;
    erid_pkg::cmd_t  cmd;
    logic            has_room;
    logic            pop;
    logic            head_valid;
    erid_pkg::cmd_t  head_cmd;

    erid_pkg::kind_t out_kind;
    logic [15:0]     out_width, out_height, out_length;
    logic [31:0]     out_start;
    logic [7:0]      out_value;
    logic            out_overrun;

    // The parser takes a beat whenever the queue can hold one more command, even
    // if the beat turns out to produce none.
    assign s_tready  = has_room;
    assign in_accept = s_tvalid && s_tready;

    erid_front u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .in_accept (in_accept),
        .in_byte   (s_tdata),
        .in_sof    (s_tuser[0]),
        .cmd_push  (cmd_push),
        .cmd       (cmd)
    );

    erid_cmd_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (cmd_push),
        .push_cmd   (cmd),
        .has_room   (has_room),
        .pop        (pop),
        .head_valid (head_valid),
        .head_cmd   (head_cmd)
    );

    erid_back u_back (
        .aclk        (aclk),
        .aresetn     (aresetn),
        .head_valid  (head_valid),
        .head_cmd    (head_cmd),
        .pop         (pop),
        .out_ready   (m_tready),
        .out_valid   (m_tvalid),
        .out_kind    (out_kind),
        .out_width   (out_width),
        .out_height  (out_height),
        .out_start   (out_start),
        .out_value   (out_value),
        .out_length  (out_length),
        .out_overrun (out_overrun)
    );

    // Pack the result fields lowest first and pad to whole bytes.
    assign m_tdata = {7'd0, out_overrun, out_length, out_value, out_start,
                      out_height, out_width};
    assign m_tuser = out_kind;

endmodule

`default_nettype wire
